FILE: rtl/dar_pkg.sv
// Shared constants, types and CORDIC tables of the deflection azimuth rotator.
package dar_pkg;

  localparam int DATA_W    = 32;
  localparam int ANGLE_W   = 32;
  localparam int STAGES    = 30;
  localparam int GAIN_W    = 32;
  localparam int CFG_IDX_W = 1;

  // Internal coordinate width: the rotation grows the vector by about 2.33 at most.
  localparam int XW = DATA_W + 3;
  // Magnitude width after taking the absolute value of a coordinate.
  localparam int MW = XW - 1;
  // Width of the gain-correction product.
  localparam int PW = MW + GAIN_W;

  typedef logic signed [XW-1:0]      coord_t;
  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic [MW-1:0]             mag_t;
  typedef logic [PW-1:0]             prod_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_XI  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ETA = 1'b1;

  // Product of cos(atan 2^-i) over all stages, scaled by 2^32 and rounded.
  localparam logic [GAIN_W-1:0] GAIN = 32'd2608131496;

  // Micro-rotation angles as binary angles, one full turn is 2^32.
  localparam logic [ANGLE_W-1:0] STEP_ANGLE [STAGES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
    32'd20,        32'd10,        32'd5,         32'd3,        32'd1
  };

endpackage

FILE: rtl/deflection_azimuth_rotator.sv
// Pipelined CORDIC rotator that turns the stored deflection pair by an input azimuth.
//
//   channel  ports                                     direction  one item
//   in       in_valid, in_stall, in_azimuth            to block   one azimuth
//   out      out_valid, out_stall, out_xi_along_azimuth,
//            out_eta_across_azimuth, out_saturated     from block one rotated pair
//   cfg      cfg_wr_en, cfg_index, cfg_wdata           to block   one register write
//
// The block accepts one item per clock cycle while in_stall is low. Every item passes
// 34 registers from acceptance to the output: one quadrant stage, one stage for each
// of the 30 micro-rotations, one absolute-value stage, one gain multiply stage and
// the output register. Reset (synchronous, rst_n low) clears the valid bits, the
// skid entry and both deflection registers. A stall on the output freezes the
// pipeline only once the skid entry behind the output register is occupied;
// in_stall is that registered occupancy flag, so it never depends on out_stall in
// the same cycle.
module deflection_azimuth_rotator
  import dar_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata,

  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [ANGLE_W-1:0]   in_azimuth,

  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [DATA_W-1:0]    out_xi_along_azimuth,
  output logic [DATA_W-1:0]    out_eta_across_azimuth,
  output logic                 out_saturated
);

  // Deflection registers, signed Q1.30. With 30 internal fraction bits they enter
  // the data path unscaled.
  logic [DATA_W-1:0] xi_r;
  logic [DATA_W-1:0] eta_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xi_r  <= '0;
      eta_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_XI:  xi_r  <= cfg_wdata;
        REG_ETA: eta_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The whole pipeline moves together. It holds only while the skid entry is full,
  // which happens when the output register is stalled and one more item arrived.
  logic skid_valid_r;
  logic adv;

  assign adv      = !skid_valid_r;
  assign in_stall = skid_valid_r;

  // Quadrant stage. Rounding the angle to the nearest quarter turn leaves a
  // residual within plus or minus one eighth of a turn for the micro-rotations.
  localparam logic [ANGLE_W-1:0] EIGHTH = ANGLE_W'(1) << (ANGLE_W - 3);

  logic [ANGLE_W-1:0] az_biased;
  logic [1:0]         quad;
  logic [ANGLE_W-1:0] az_resid;
  coord_t             xi_ext;
  coord_t             eta_ext;
  coord_t             x0_nxt;
  coord_t             y0_nxt;

  assign az_biased = in_azimuth + EIGHTH;
  assign quad      = az_biased[ANGLE_W-1 -: 2];
  assign az_resid  = in_azimuth - {quad, {(ANGLE_W-2){1'b0}}};
  assign xi_ext    = coord_t'($signed(xi_r));
  assign eta_ext   = coord_t'($signed(eta_r));

  // Each quarter turn maps (x, y) to (y, -x).
  always_comb begin
    case (quad)
      2'd0: begin
        x0_nxt = xi_ext;
        y0_nxt = eta_ext;
      end
      2'd1: begin
        x0_nxt = eta_ext;
        y0_nxt = -xi_ext;
      end
      2'd2: begin
        x0_nxt = -xi_ext;
        y0_nxt = -eta_ext;
      end
      2'd3: begin
        x0_nxt = -eta_ext;
        y0_nxt = xi_ext;
      end
      default: begin
        x0_nxt = xi_ext;
        y0_nxt = eta_ext;
      end
    endcase
  end

  // Micro-rotation pipeline: entry 0 is the quadrant stage, entry i+1 holds the
  // result of micro-rotation i.
  logic   valid_r [STAGES+1];
  coord_t x_r     [STAGES+1];
  coord_t y_r     [STAGES+1];
  angle_t z_r     [STAGES];
  coord_t x_nxt   [STAGES];
  coord_t y_nxt   [STAGES];
  angle_t z_nxt   [STAGES-1];

  // Both updates of a stage use the coordinates from before the stage; the sign of
  // the residual angle picks the direction of the turn.
  always_comb begin
    for (int i = 0; i < STAGES; i++) begin
      if (!z_r[i][ANGLE_W-1]) begin
        x_nxt[i] = x_r[i] + (y_r[i] >>> i);
        y_nxt[i] = y_r[i] - (x_r[i] >>> i);
      end else begin
        x_nxt[i] = x_r[i] - (y_r[i] >>> i);
        y_nxt[i] = y_r[i] + (x_r[i] >>> i);
      end
    end
    for (int i = 0; i < STAGES - 1; i++) begin
      z_nxt[i] = z_r[i][ANGLE_W-1] ? z_r[i] + angle_t'(STEP_ANGLE[i])
                                   : z_r[i] - angle_t'(STEP_ANGLE[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= STAGES; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else if (adv) begin
      valid_r[0] <= in_valid;
      for (int i = 0; i < STAGES; i++) begin
        valid_r[i+1] <= valid_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r[0] <= x0_nxt;
      y_r[0] <= y0_nxt;
      z_r[0] <= angle_t'(az_resid);
      for (int i = 0; i < STAGES; i++) begin
        x_r[i+1] <= x_nxt[i];
        y_r[i+1] <= y_nxt[i];
      end
      for (int i = 0; i < STAGES - 1; i++) begin
        z_r[i+1] <= z_nxt[i];
      end
    end
  end

  // Absolute-value stage. The rotated vector stays well below 2^33 in magnitude.
  logic   abs_valid_r;
  logic   x_neg_r;
  logic   y_neg_r;
  mag_t   x_mag_r;
  mag_t   y_mag_r;
  coord_t x_fin;
  coord_t y_fin;
  coord_t x_abs;
  coord_t y_abs;

  assign x_fin = x_r[STAGES];
  assign y_fin = y_r[STAGES];
  assign x_abs = x_fin[XW-1] ? -x_fin : x_fin;
  assign y_abs = y_fin[XW-1] ? -y_fin : y_fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      abs_valid_r <= 1'b0;
    end else if (adv) begin
      abs_valid_r <= valid_r[STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_neg_r <= x_fin[XW-1];
      y_neg_r <= y_fin[XW-1];
      x_mag_r <= x_abs[MW-1:0];
      y_mag_r <= y_abs[MW-1:0];
    end
  end

  // Gain-correction multiply stage.
  logic  mul_valid_r;
  logic  x_sign_r;
  logic  y_sign_r;
  prod_t x_prod_r;
  prod_t y_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
    end else if (adv) begin
      mul_valid_r <= abs_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_sign_r <= x_neg_r;
      y_sign_r <= y_neg_r;
      x_prod_r <= PW'(x_mag_r) * PW'(GAIN);
      y_prod_r <= PW'(y_mag_r) * PW'(GAIN);
    end
  end

  // Rounding, half away from zero on the magnitude, then clipping to the output range.
  localparam prod_t HALF    = PW'(1) << (GAIN_W - 1);
  localparam mag_t  LIM_POS = (MW'(1) << (DATA_W - 1)) - MW'(1);
  localparam mag_t  LIM_NEG = MW'(1) << (DATA_W - 1);

  function automatic logic [DATA_W:0] round_clip(input prod_t prod, input logic neg);
    prod_t             rnd;
    mag_t              mag;
    mag_t              lim;
    logic              clip;
    logic [DATA_W-1:0] res;
    rnd  = prod + HALF;
    mag  = rnd[PW-1:GAIN_W];
    lim  = neg ? LIM_NEG : LIM_POS;
    clip = mag > lim;
    res  = clip ? lim[DATA_W-1:0] : mag[DATA_W-1:0];
    res  = neg ? -res : res;
    return {clip, res};
  endfunction

  logic [DATA_W:0]   x_done;
  logic [DATA_W:0]   y_done;
  logic [DATA_W-1:0] xi_res;
  logic [DATA_W-1:0] eta_res;
  logic              sat_res;

  assign x_done  = round_clip(x_prod_r, x_sign_r);
  assign y_done  = round_clip(y_prod_r, y_sign_r);
  assign xi_res  = x_done[DATA_W-1:0];
  assign eta_res = y_done[DATA_W-1:0];
  assign sat_res = x_done[DATA_W] | y_done[DATA_W];

  // Output register with one skid entry behind it.
  logic              out_valid_r;
  logic [DATA_W-1:0] out_xi_r;
  logic [DATA_W-1:0] out_eta_r;
  logic              out_sat_r;
  logic [DATA_W-1:0] skid_xi_r;
  logic [DATA_W-1:0] skid_eta_r;
  logic              skid_sat_r;
  logic              out_take;
  logic              deliver;
  logic              load_out;
  logic              load_skid;
  logic              load_from_skid;

  assign out_take       = out_valid_r && !out_stall;
  assign deliver        = mul_valid_r && adv;
  assign load_from_skid = skid_valid_r && out_take;
  assign load_out       = deliver && (!out_valid_r || out_take);
  assign load_skid      = deliver && out_valid_r && !out_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (load_from_skid) begin
        skid_valid_r <= 1'b0;
      end else if (load_skid) begin
        skid_valid_r <= 1'b1;
      end
      if (load_from_skid || load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_from_skid) begin
      out_xi_r  <= skid_xi_r;
      out_eta_r <= skid_eta_r;
      out_sat_r <= skid_sat_r;
    end else if (load_out) begin
      out_xi_r  <= xi_res;
      out_eta_r <= eta_res;
      out_sat_r <= sat_res;
    end
    if (load_skid) begin
      skid_xi_r  <= xi_res;
      skid_eta_r <= eta_res;
      skid_sat_r <= sat_res;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_xi_along_azimuth   = out_xi_r;
  assign out_eta_across_azimuth = out_eta_r;
  assign out_saturated          = out_sat_r;

endmodule
